// File: rtl/core/sasp_pkg.sv
package sasp_pkg;

  // input function codes
  localparam logic [1:0] FUNC_SET   = 2'd0;
  localparam logic [1:0] FUNC_SPEED = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // configuration register indexes
  localparam logic REG_LO_CMP = 1'b0;
  localparam logic REG_HI_CMP = 1'b1;

  localparam logic [15:0] LO_CMP_RST = 16'd500;
  localparam logic [15:0] HI_CMP_RST = 16'd2500;

  localparam logic signed [15:0] ANGLE_LIMIT_IN = 16'sd180;
  localparam logic [7:0]         ANGLE_LIMIT    = 8'd180;

  // step = floor(speed * 2^16 / 1000) = (speed * STEP_RECIP) >> 24
  localparam logic [30:0] STEP_RECIP = 31'd1099511628;
  // floor(q / 180) = (q * DIV180_RECIP) >> 31, exact for q < 2^31 / 52
  localparam logic [23:0] DIV180_RECIP = 24'd11930465;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_SET,
    OP_SLEW,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0]  angle;
    logic [23:0] step;
  } cmd_t;

endpackage

// File: rtl/core/sasp_in_if.sv
interface sasp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] angle;
  logic [15:0]        speed;

  modport source (output valid, func, angle, speed, input ready);
  modport sink   (input valid, func, angle, speed, output ready);
endinterface

// File: rtl/core/sasp_out_if.sv
interface sasp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] compare_value;
  logic [7:0]  angle_now;

  modport source (output valid, compare_value, angle_now, input ready);
  modport sink   (input valid, compare_value, angle_now, output ready);
endinterface

// File: rtl/core/sasp_front.sv
// Decode, clamp and step computation for each accepted transaction.
module sasp_front (
  sasp_in_if.sink        in_if,
  input  logic           full,
  output logic           push,
  output sasp_pkg::cmd_t push_cmd
);

  logic [7:0]  angle_c;
  logic [46:0] step_prod;
  logic        accept;

  assign in_if.ready = !full;
  assign accept      = in_if.valid && !full;

  always_comb begin
    if (in_if.angle[15]) begin
      angle_c = 8'd0;
    end else if (in_if.angle > sasp_pkg::ANGLE_LIMIT_IN) begin
      angle_c = sasp_pkg::ANGLE_LIMIT;
    end else begin
      angle_c = in_if.angle[7:0];
    end
  end

  assign step_prod = in_if.speed * sasp_pkg::STEP_RECIP;

  always_comb begin
    push_cmd.angle = angle_c;
    push_cmd.step  = {1'b0, step_prod[46:24]};
    push_cmd.op    = sasp_pkg::OP_TICK;
    push           = 1'b0;
    case (in_if.func)
      sasp_pkg::FUNC_SET: begin
        push_cmd.op = sasp_pkg::OP_SET;
        push        = accept;
      end
      sasp_pkg::FUNC_SPEED: begin
        push_cmd.op = (in_if.speed == 16'd0) ? sasp_pkg::OP_SET : sasp_pkg::OP_SLEW;
        push        = accept;
      end
      sasp_pkg::FUNC_TICK: begin
        push_cmd.op = sasp_pkg::OP_TICK;
        push        = accept;
      end
      default: begin
        // unused code: consumed, no effect
        push = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/sasp_queue.sv
// Small command queue between front and back.
module sasp_queue #(
  parameter int unsigned DEPTH = sasp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sasp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sasp_pkg::cmd_t head_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sasp_pkg::cmd_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/sasp_back.sv
// Slew state update and pulse mapping pipeline.
module sasp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  sasp_pkg::cmd_t head_cmd,
  output logic           pop,
  input  logic [15:0]    span,
  input  logic [15:0]    lo_cmp,
  sasp_out_if.source     out_if
);

  logic [23:0] pos_r, pos_nxt;
  logic [7:0]  goal_r, goal_nxt;
  logic [23:0] step_r, step_nxt;
  logic        emit;

  logic [23:0] goal_q;
  logic [24:0] sum;
  logic [23:0] diff;

  logic        adv;

  logic        s1_valid_r;
  logic [23:0] s1_pos_r;
  logic        s2_valid_r;
  logic [39:0] s2_prod_r;
  logic [7:0]  s2_angle_r;
  logic        s3_valid_r;
  logic [47:0] s3_mul_r;
  logic [7:0]  s3_angle_r;
  logic        out_valid_r;
  logic [15:0] out_cmp_r;
  logic [7:0]  out_angle_r;

  assign adv = !out_valid_r || out_if.ready;
  assign pop = adv && head_valid;

  assign goal_q = {goal_r, 16'd0};
  assign sum    = {1'b0, pos_r} + {1'b0, step_r};
  assign diff   = pos_r - goal_q;

  always_comb begin
    pos_nxt  = pos_r;
    goal_nxt = goal_r;
    step_nxt = step_r;
    emit     = 1'b0;
    case (head_cmd.op)
      sasp_pkg::OP_SET: begin
        pos_nxt  = {head_cmd.angle, 16'd0};
        goal_nxt = head_cmd.angle;
        step_nxt = '0;
        emit     = 1'b1;
      end
      sasp_pkg::OP_SLEW: begin
        goal_nxt = head_cmd.angle;
        step_nxt = head_cmd.step;
      end
      sasp_pkg::OP_TICK: begin
        if (step_r != '0 && pos_r[23:16] != goal_r) begin
          emit = 1'b1;
          if (pos_r < goal_q) begin
            pos_nxt = (sum > {1'b0, goal_q}) ? goal_q : sum[23:0];
          end else begin
            pos_nxt = (diff < step_r) ? goal_q : pos_r - step_r;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      goal_r <= '0;
      step_r <= '0;
    end else if (pop) begin
      pos_r  <= pos_nxt;
      goal_r <= goal_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= pop && emit;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pos_r    <= pos_nxt;
      s2_prod_r   <= span * s1_pos_r;
      s2_angle_r  <= s1_pos_r[23:16];
      s3_mul_r    <= s2_prod_r[39:16] * sasp_pkg::DIV180_RECIP;
      s3_angle_r  <= s2_angle_r;
      out_cmp_r   <= lo_cmp + s3_mul_r[46:31];
      out_angle_r <= s3_angle_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.compare_value = out_cmp_r;
  assign out_if.angle_now     = out_angle_r;

endmodule

// File: rtl/core/servo_angle_slew_to_pulse_core.sv
// Servo slew limiter with PWM compare output. Takes one transaction per clock
// cycle while the queue is not full: immediate set (func 0, or func 1 with
// speed 0), slewed set (func 1) and the one-millisecond tick (func 2); func 3
// is swallowed. Angles clamp to 0..180 degrees. A set emits a result at once,
// a slewed set emits nothing, a tick emits one only while the position is
// moving. The front decodes and computes the Q8.16 step, a QUEUE_DEPTH-entry
// command queue decouples it from the back, which updates position/goal/step
// as each command is popped and maps the position to lo_cmp + floor(span *
// position / 180) through a pipeline of registers (position, span * position,
// reciprocal divide by 180, add). With an empty queue a command passes the
// queue, the state update, the two multiplies and the add before its result
// is valid; sustained rate is one transaction per cycle, limited only by
// output backpressure. Write lo_cmp (register 0) and hi_cmp (register 1)
// only while idle; hi_cmp below lo_cmp gives a zero span.
module servo_angle_slew_to_pulse_core #(
  parameter int unsigned QUEUE_DEPTH = sasp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata,
  // command and result channels
  sasp_in_if.sink     in_if,
  sasp_out_if.source  out_if
);

  logic [15:0] lo_cmp_r;
  logic [15:0] hi_cmp_r;
  logic [15:0] span;

  logic           push;
  sasp_pkg::cmd_t push_cmd;
  logic           full;
  logic           pop;
  logic           head_valid;
  sasp_pkg::cmd_t head_cmd;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_cmp_r <= sasp_pkg::LO_CMP_RST;
      hi_cmp_r <= sasp_pkg::HI_CMP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        sasp_pkg::REG_LO_CMP: lo_cmp_r <= cfg_wdata;
        sasp_pkg::REG_HI_CMP: hi_cmp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // reversed limits collapse to zero span
  assign span = (hi_cmp_r >= lo_cmp_r) ? (hi_cmp_r - lo_cmp_r) : 16'd0;

  sasp_front u_front (
    .in_if    (in_if),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  sasp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  sasp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .span       (span),
    .lo_cmp     (lo_cmp_r),
    .out_if     (out_if)
  );

endmodule

// File: tb/sasp_pulse_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels and the register port, keeps its
// own copy of the servo state and checks each result against the oldest
// predicted pulse.
module sasp_pulse_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata,
  sasp_in_if          in_ch,
  sasp_out_if         out_ch,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [15:0] cmp;
    logic [7:0]  deg;
  } pulse_t;

  logic [15:0] lo_cmp_q;
  logic [15:0] hi_cmp_q;
  logic [23:0] pos_q;   // Q8.16 degrees
  logic [23:0] step_q;  // Q8.16 degrees per tick
  logic [7:0]  goal_q;
  pulse_t      expected_pulses[$];
  int          mismatches;
  int          results_seen;

  function automatic logic [7:0] clamp_deg(logic signed [15:0] a);
    if (a < 0) return 8'd0;
    if (a > sasp_pkg::ANGLE_LIMIT_IN) return sasp_pkg::ANGLE_LIMIT;
    return a[7:0];
  endfunction

  // lo + floor(span * pos / 180), pos in Q8.16
  function automatic logic [15:0] pulse_of(logic [23:0] p);
    logic [63:0] span;
    logic [63:0] off;
    span = (hi_cmp_q >= lo_cmp_q) ? 64'(hi_cmp_q - lo_cmp_q) : 64'd0;
    off  = (span * 64'(p)) / (64'(sasp_pkg::ANGLE_LIMIT) << 16);
    return 16'(64'(lo_cmp_q) + off);
  endfunction

  task automatic push_pulse();
    pulse_t p;
    p.cmp = pulse_of(pos_q);
    p.deg = pos_q[23:16];
    expected_pulses.push_back(p);
  endtask

  task automatic apply_cmd(logic [1:0] f, logic signed [15:0] a, logic [15:0] spd);
    logic [23:0] g;
    logic [24:0] sum;
    if (f == sasp_pkg::FUNC_SET || (f == sasp_pkg::FUNC_SPEED && spd == 16'd0)) begin
      goal_q = clamp_deg(a);
      pos_q  = {goal_q, 16'h0000};
      step_q = '0;
      push_pulse();
    end else if (f == sasp_pkg::FUNC_SPEED) begin
      // position untouched; only goal and step change
      goal_q = clamp_deg(a);
      step_q = 24'((32'(spd) << 16) / 32'd1000);
    end else if (f == sasp_pkg::FUNC_TICK && step_q != '0 && pos_q[23:16] != goal_q) begin
      g = {goal_q, 16'h0000};
      if (pos_q < g) begin
        sum   = 25'(pos_q) + 25'(step_q);
        pos_q = (sum > 25'(g)) ? g : sum[23:0];
      end else begin
        pos_q = (pos_q - g < step_q) ? g : pos_q - step_q;
      end
      push_pulse();
    end
    // idle tick and the spare selector fall through with no result
  endtask

  always @(posedge clk) begin
    pulse_t want;
    if (!rst_n) begin
      lo_cmp_q     = sasp_pkg::LO_CMP_RST;
      hi_cmp_q     = sasp_pkg::HI_CMP_RST;
      pos_q        = '0;
      step_q       = '0;
      goal_q       = '0;
      mismatches   = 0;
      results_seen = 0;
      expected_pulses.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == sasp_pkg::REG_LO_CMP) lo_cmp_q = cfg_wdata;
        else lo_cmp_q = lo_cmp_q;
        if (cfg_idx == sasp_pkg::REG_HI_CMP) hi_cmp_q = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_pulses.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result cmp=%0d angle=%0d", $realtime,
                     out_ch.compare_value, out_ch.angle_now);
          mismatches++;
        end else begin
          want = expected_pulses.pop_front();
          if (out_ch.compare_value !== want.cmp || out_ch.angle_now !== want.deg) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected cmp=%0d angle=%0d, got cmp=%0d angle=%0d",
                       $realtime, want.cmp, want.deg, out_ch.compare_value,
                       out_ch.angle_now);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        apply_cmd(in_ch.func, in_ch.angle, in_ch.speed);
    end
    fail_count <= mismatches;
    pending    <= expected_pulses.size();
    checked    <= results_seen;
  end

endmodule

// File: tb/tb_servo_angle_slew_to_pulse_core.sv
`timescale 1ns / 1ps

// Top level: clock, reset, command stimulus, result backpressure and verdict.
// All prediction and comparison lives in sasp_pulse_checker.
module tb_servo_angle_slew_to_pulse_core;

  // selector value the block must swallow without a result
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  // settle time after draining, for a command to pass through the queue and
  // the result pipeline with an empty queue
  localparam int SETTLE_CYCLES = 10;
  // long receiver hold-off used to fill the command queue
  localparam int HOLD_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_wdata;
  logic        hold_req;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int burst_left;
  int limit_sets;

  sasp_in_if  in_if ();
  sasp_out_if out_if ();

  servo_angle_slew_to_pulse_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_if),
    .out_if   (out_if)
  );

  sasp_pulse_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  always #5 clk = ~clk;

  // Watchdog: the slowest legal run is far below this.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one command and hold it until the block takes it. The do-while
  // samples ready at each edge; valid is already high at the first one.
  task automatic send_cmd(logic [1:0] f, logic signed [15:0] a, logic [15:0] spd);
    in_if.valid <= 1'b1;
    in_if.func  <= f;
    in_if.angle <= a;
    in_if.speed <= spd;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  // Burst/gap pacing for the sender. Now and then a long burst gives a
  // stretch with no gaps at all.
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every predicted result has been seen,
  // then let commands with no result work their way out of the pipe.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic set_limits(logic [15:0] lo, logic [15:0] hi);
    cfg_we    <= 1'b1;
    cfg_idx   <= sasp_pkg::REG_LO_CMP;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx   <= sasp_pkg::REG_HI_CMP;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_sets++;
  endtask

  // Mostly in range, some just outside and some anywhere in 16 bits.
  function automatic logic signed [15:0] pick_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(0, 180));
    if (r < 90) return 16'($urandom_range(181, 400));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Slow speeds give sub-degree steps, fast ones reach the goal in a few ticks.
  function automatic logic [15:0] pick_speed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 16'($urandom_range(1, 999));
    if (r < 70) return 16'($urandom_range(1000, 20000));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Random traffic: mostly slewed moves followed by a run of ticks, with
  // immediate sets, zero-speed sets and junk mixed in.
  task automatic random_phase(int n);
    int target;
    int kind;
    int ticks;
    target = sent + n;
    while (sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        send_cmd(sasp_pkg::FUNC_SET, pick_angle(), 16'($urandom_range(0, 65535)));
        pace();
      end else if (kind < 16) begin
        send_cmd(sasp_pkg::FUNC_SPEED, pick_angle(), 16'd0);
        pace();
      end else if (kind < 22) begin
        // noise: spare selector or a stray tick, random payload
        send_cmd(($urandom_range(0, 1) == 0) ? FUNC_SPARE : sasp_pkg::FUNC_TICK,
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        pace();
      end else begin
        send_cmd(sasp_pkg::FUNC_SPEED, pick_angle(), pick_speed());
        pace();
        ticks = $urandom_range(1, 40);
        for (int i = 0; i < ticks; i++) begin
          // angle and speed are don't-care on a tick, so randomize them
          send_cmd(sasp_pkg::FUNC_TICK, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
          pace();
        end
      end
    end
  endtask

  // Result side backpressure. Runs its own pattern of stretches; when the
  // stimulus raises hold_req it stalls for HOLD_CYCLES once, so the queue
  // fills and the block must push back on the command channel.
  initial begin
    int mode;
    int len;
    bit held;
    bit rdy;
    held = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 80);
      for (int i = 0; i < len; i++) begin
        if (hold_req && !held) begin
          held = 1'b1;
          out_if.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        if (!hold_req) held = 1'b0;
        case (mode)
          0: begin
            rdy = 1'b1;
          end
          1: begin
            rdy = ($urandom_range(0, 99) < 65);
          end
          2: begin
            rdy = i[0];
          end
          default: begin
            rdy = ($urandom_range(0, 99) < 25);
          end
        endcase
        out_if.ready <= rdy;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [15:0] lo;
    logic [15:0] hi;
    sent       = 0;
    burst_left = 1;
    limit_sets = 1;  // reset values count as the first setting
    rst_n       <= 1'b0;
    hold_req    <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= sasp_pkg::REG_LO_CMP;
    cfg_wdata   <= '0;
    in_if.valid <= 1'b0;
    in_if.func  <= sasp_pkg::FUNC_SET;
    in_if.angle <= '0;
    in_if.speed <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, with the reset limits 500..2500.
    // angle extremes and clamping on immediate sets
    send_cmd(sasp_pkg::FUNC_SET, 16'sd0, 16'd0);             pace();
    send_cmd(sasp_pkg::FUNC_SET, 16'sd180, 16'd0);           pace();
    send_cmd(sasp_pkg::FUNC_SET, 16'sh8000, 16'hFFFF);       pace();
    send_cmd(sasp_pkg::FUNC_SET, 16'sh7FFF, 16'd0);          pace();
    send_cmd(sasp_pkg::FUNC_SET, 16'sd181, 16'd0);           pace();
    send_cmd(sasp_pkg::FUNC_SET, -16'sd1, 16'd0);            pace();
    send_cmd(sasp_pkg::FUNC_SET, 16'sd90, 16'd0);            pace();
    // zero speed behaves as an immediate set
    send_cmd(sasp_pkg::FUNC_SPEED, 16'sd45, 16'd0);          pace();
    // tick with no step stored: nothing comes out
    send_cmd(sasp_pkg::FUNC_TICK, 16'sd0, 16'd0);            pace();
    // fastest slew: two full steps, clamp at goal, then an idle tick
    send_cmd(sasp_pkg::FUNC_SPEED, 16'sd180, 16'hFFFF);      pace();
    repeat (4) begin
      send_cmd(sasp_pkg::FUNC_TICK, 16'sh7FFF, 16'hFFFF);    pace();
    end
    // slowest slew: smallest nonzero step
    send_cmd(sasp_pkg::FUNC_SPEED, 16'sd0, 16'd1);           pace();
    repeat (2) begin
      send_cmd(sasp_pkg::FUNC_TICK, 16'sd0, 16'd0);          pace();
    end
    // goal equals integer part, fraction above it stays: idle tick
    send_cmd(sasp_pkg::FUNC_SPEED, 16'sd179, 16'd1000);      pace();
    send_cmd(sasp_pkg::FUNC_TICK, 16'sd0, 16'd0);            pace();
    send_cmd(sasp_pkg::FUNC_SPEED, 16'sd0, 16'd1000);        pace();
    send_cmd(sasp_pkg::FUNC_TICK, 16'sd0, 16'd0);            pace();
    // spare selector is swallowed
    send_cmd(FUNC_SPARE, -16'sd1, 16'hFFFF);                 pace();

    random_phase(280);
    drain();

    // widest span
    set_limits(16'd0, 16'hFFFF);
    random_phase(280);
    drain();

    // reversed limits: span counts as zero
    set_limits(16'hFFFF, 16'd0);
    random_phase(150);
    drain();

    set_limits(16'd1234, 16'd1234);
    random_phase(100);
    drain();

    set_limits(16'hFFFF, 16'hFFFF);
    random_phase(60);
    drain();

    set_limits(16'd0, 16'd0);
    random_phase(60);
    drain();

    lo = 16'($urandom_range(0, 30000));
    hi = 16'($urandom_range(lo, 65535));
    set_limits(lo, hi);
    // Back-to-back immediate sets while the receiver holds off: the
    // queue fills and the command channel has to stall.
    hold_req <= 1'b1;
    for (int i = 0; i < 30; i++)
      send_cmd(sasp_pkg::FUNC_SET, pick_angle(), 16'($urandom_range(0, 65535)));
    hold_req <= 1'b0;
    drain();
    random_phase(380);
    drain();

    $display("Run summary: %0d command transactions, %0d pulse results checked",
             sent, checked);
    $display("  over %0d limit settings incl. reversed, equal and full-range spans",
             limit_sets);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
